FILE: hdl/sbtg_pkg.sv
// Shared types and constants for the spectral band taper gain block.
package sbtg_pkg;

	typedef enum logic [1:0] {
		MODE_BAND_PASS = 2'd0,
		MODE_HIGH_PASS = 2'd1,
		MODE_LOW_PASS  = 2'd2
	} band_mode_t;

	typedef enum logic [2:0] {
		REG_BAND_MODE   = 3'd0,
		REG_BAND_MIN    = 3'd1,
		REG_BAND_PEAK   = 3'd2,
		REG_BAND_MAX    = 3'd3,
		REG_INVERT_GAIN = 3'd4
	} reg_index_t;

	localparam int unsigned WN_W  = 16;
	localparam int unsigned CFG_W = 16;
	localparam int unsigned IDX_W = 3;

	// sine datapath: argument and polynomial terms in Q30
	localparam int unsigned X_W = 30;
	localparam int unsigned P_W = 31;

	localparam logic [P_W-1:0] SIN_C1 = 31'd1686629713;
	localparam logic [P_W-1:0] SIN_C3 = 31'd693598668;
	localparam logic [P_W-1:0] SIN_C5 = 31'd85569306;
	localparam logic [P_W-1:0] SIN_C7 = 31'd5026995;
	localparam logic [P_W-1:0] SIN_C9 = 31'd172272;

	localparam int unsigned HORNER_N = 4;
	localparam logic [P_W-1:0] SIN_HORNER [HORNER_N] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

endpackage

FILE: hdl/sbtg_if.sv
// Valid/ready channels for input items and results.
interface sbtg_item_if #(
	parameter int unsigned SAMPLE_WIDTH = 32
);
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [sbtg_pkg::WN_W-1:0]      wavenumber;
	logic signed [SAMPLE_WIDTH-1:0] sample_value;

	modport source (output valid, kind, wavenumber, sample_value, input ready);
	modport sink (input valid, kind, wavenumber, sample_value, output ready);
endinterface

interface sbtg_result_if #(
	parameter int unsigned SAMPLE_WIDTH = 32
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] filtered_value;
	logic                           saturated;

	modport source (output valid, filtered_value, saturated, input ready);
	modport sink (input valid, filtered_value, saturated, output ready);
endinterface

FILE: hdl/sbtg_div_cell.sv
// One restoring division step: shifts in a dividend bit, emits one quotient bit.
module sbtg_div_cell #(
	parameter int unsigned RW = 16,
	parameter int unsigned QW = 30,
	parameter int unsigned TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  logic [RW-1:0] rem_i,
	input  logic [QW-1:0] qs_i,
	input  logic [RW-1:0] dv_i,
	input  logic [TW-1:0] tag_i,
	output logic          v_o,
	output logic [RW-1:0] rem_o,
	output logic [QW-1:0] qs_o,
	output logic [RW-1:0] dv_o,
	output logic [TW-1:0] tag_o
);

	logic [RW:0]   rem2;
	logic          ge;
	logic [RW:0]   diff;

	logic          v_s1;
	logic [RW-1:0] rem_s1;
	logic [QW-1:0] qs_s1;
	logic [RW-1:0] dv_s1;
	logic [TW-1:0] tag_s1;

	assign rem2 = {rem_i, qs_i[QW-1]};
	assign diff = rem2 - {1'b0, dv_i};
	assign ge   = (rem2 >= {1'b0, dv_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= ge ? diff[RW-1:0] : rem2[RW-1:0];
			qs_s1  <= {qs_i[QW-2:0], ge};
			dv_s1  <= dv_i;
			tag_s1 <= tag_i;
		end
	end

	assign v_o   = v_s1;
	assign rem_o = rem_s1;
	assign qs_o  = qs_s1;
	assign dv_o  = dv_s1;
	assign tag_o = tag_s1;

endmodule

FILE: hdl/sbtg_horner_cell.sv
// One Horner step of the sine polynomial: p_out = C - ((u * p_in) >> 30).
module sbtg_horner_cell #(
	parameter logic [sbtg_pkg::P_W-1:0] COEF = '0,
	parameter int unsigned TW = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_i,
	input  logic [sbtg_pkg::X_W-1:0] u_i,
	input  logic [sbtg_pkg::P_W-1:0] p_i,
	input  logic [TW-1:0]            tag_i,
	output logic                     v_o,
	output logic [sbtg_pkg::X_W-1:0] u_o,
	output logic [sbtg_pkg::P_W-1:0] p_o,
	output logic [TW-1:0]            tag_o
);

	localparam int unsigned PR_W = sbtg_pkg::X_W + sbtg_pkg::P_W;

	logic [PR_W-1:0]            prod;
	logic                       v_s1;
	logic [sbtg_pkg::X_W-1:0]   u_s1;
	logic [sbtg_pkg::P_W-1:0]   p_s1;
	logic [TW-1:0]              tag_s1;

	assign prod = PR_W'(u_i) * PR_W'(p_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1   <= u_i;
			p_s1   <= COEF - prod[PR_W-1:sbtg_pkg::X_W];
			tag_s1 <= tag_i;
		end
	end

	assign v_o   = v_s1;
	assign u_o   = u_s1;
	assign p_o   = p_s1;
	assign tag_o = tag_s1;

endmodule

FILE: hdl/spectral_band_taper_gain.sv
// Top level of the spectral band taper gain block.
// Takes one item per clock when not held and returns one result per item, in order.
// A 30-cell chain of division cells computes the taper position, four Horner cells the
// sine, and two DW-cell chains of division cells the reciprocals, with
// DW = max(2*GAIN_FRAC_BITS, max(GAIN_FRAC_BITS+1, SAMPLE_WIDTH)-1) + 1.
// The whole pipeline moves together; it holds only while the output register carries
// an untaken result and a finished item waits behind it.
// Configuration takes effect for items accepted after the write.
module spectral_band_taper_gain #(
	parameter int unsigned GAIN_FRAC_BITS = 16,
	parameter int unsigned SAMPLE_WIDTH   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [sbtg_pkg::IDX_W-1:0]     wr_index,
	input  logic [sbtg_pkg::CFG_W-1:0]     wr_data,
	sbtg_item_if.sink                      item,
	sbtg_result_if.source                  result
);

	localparam int unsigned F     = GAIN_FRAC_BITS;
	localparam int unsigned SW    = SAMPLE_WIDTH;
	localparam int unsigned GW    = (F + 1 > SW) ? F + 1 : SW;
	localparam int unsigned DW    = ((2 * F > GW - 1) ? 2 * F : GW - 1) + 1;
	localparam int unsigned NA    = (SW + 31) / 32;
	localparam int unsigned NB    = (GW + 31) / 32;
	localparam int unsigned PW    = 32 * (NA + NB);
	localparam int unsigned FW    = PW - F;
	localparam int unsigned XW    = sbtg_pkg::X_W;
	localparam int unsigned PWS   = sbtg_pkg::P_W;
	localparam int unsigned WW    = sbtg_pkg::WN_W;
	localparam int unsigned T1W   = SW + 5;
	localparam int unsigned THW   = XW + T1W;
	localparam int unsigned TRW   = SW + 3;
	localparam int unsigned DIV_N = XW;
	localparam int unsigned HN    = sbtg_pkg::HORNER_N;

	localparam logic [GW-1:0] GAIN_ONE = GW'(1) << F;
	localparam logic [DW-1:0] RCP_ONE  = DW'(1) << (2 * F);
	localparam logic [DW-1:0] LIM_DW   = {{(DW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
	localparam logic [GW-1:0] LIM_GW   = {{(GW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
	localparam logic [FW-1:0] LIM_FW   = {{(FW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
	localparam logic [62:0]   G_RND    = 63'd1 << (59 - F);
	localparam logic [PW-1:0] P_RND    = PW'(1) << (F - 1);

	// configuration registers
	sbtg_pkg::band_mode_t mode_q;
	logic [WW-1:0]        min_q;
	logic [WW-1:0]        peak_q;
	logic [WW-1:0]        max_q;
	logic                 inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sbtg_pkg::MODE_BAND_PASS;
			min_q  <= '0;
			peak_q <= '0;
			max_q  <= '0;
			inv_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (sbtg_pkg::reg_index_t'(wr_index))
				sbtg_pkg::REG_BAND_MODE:   mode_q <= sbtg_pkg::band_mode_t'(wr_data[1:0]);
				sbtg_pkg::REG_BAND_MIN:    min_q  <= wr_data[WW-1:0];
				sbtg_pkg::REG_BAND_PEAK:   peak_q <= wr_data[WW-1:0];
				sbtg_pkg::REG_BAND_MAX:    max_q  <= wr_data[WW-1:0];
				sbtg_pkg::REG_INVERT_GAIN: inv_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// pipeline advance
	logic en;
	logic out_load;
	logic v_s9;
	logic res_valid_q;

	assign out_load   = !res_valid_q || result.ready;
	assign en         = out_load || !v_s9;
	assign item.ready = en;

	// stage 1: band region and taper edge operands
	logic          kind_c;
	logic [WW-1:0] k_c;
	logic          neg_c;
	logic [SW-1:0] mag_c;
	logic [WW-1:0] num_c;
	logic [WW-1:0] den_c;
	logic          zero_c;
	logic          one_c;
	logic          tp_c;

	assign kind_c = item.kind;
	assign k_c    = item.wavenumber;
	assign neg_c  = item.sample_value[SW-1];
	assign mag_c  = neg_c ? (SW'(0) - SW'(item.sample_value)) : SW'(item.sample_value);

	always_comb begin
		zero_c = 1'b0;
		one_c  = 1'b0;
		tp_c   = 1'b0;
		num_c  = '0;
		den_c  = '0;
		case (mode_q)
			sbtg_pkg::MODE_BAND_PASS: begin
				if (k_c > min_q && k_c <= peak_q) begin
					tp_c  = 1'b1;
					num_c = k_c - min_q;
					den_c = peak_q - min_q;
				end else if (k_c > peak_q && k_c < max_q) begin
					tp_c  = 1'b1;
					num_c = max_q - k_c;
					den_c = max_q - peak_q;
				end else begin
					zero_c = 1'b1;
				end
			end
			sbtg_pkg::MODE_HIGH_PASS: begin
				if (k_c > peak_q) begin
					one_c = 1'b1;
				end else if (k_c > min_q) begin
					tp_c  = 1'b1;
					num_c = k_c - min_q;
					den_c = peak_q - min_q;
				end else begin
					zero_c = 1'b1;
				end
			end
			sbtg_pkg::MODE_LOW_PASS: begin
				if (k_c < peak_q) begin
					one_c = 1'b1;
				end else if (k_c <= max_q) begin
					tp_c  = 1'b1;
					num_c = max_q - k_c;
					den_c = max_q - peak_q;
				end else begin
					zero_c = 1'b1;
				end
			end
			default: zero_c = 1'b1;
		endcase
		if (tp_c) begin
			if (num_c == '0 || den_c == '0) begin
				zero_c = 1'b1;
			end else if (num_c >= den_c) begin
				one_c = 1'b1;
			end
		end
	end

	logic           v_s1;
	logic [T1W-1:0] tag_s1;
	logic [WW-1:0]  num_s1;
	logic [WW-1:0]  den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= {kind_c, inv_q, neg_c, zero_c, one_c, mag_c};
			num_s1 <= num_c;
			den_s1 <= den_c;
		end
	end

	// taper position x = (num << 30) / den, one quotient bit per cell
	logic           dv_v   [DIV_N+1];
	logic [WW-1:0]  dv_rem [DIV_N+1];
	logic [XW-1:0]  dv_qs  [DIV_N+1];
	logic [WW-1:0]  dv_den [DIV_N+1];
	logic [T1W-1:0] dv_tag [DIV_N+1];

	assign dv_v[0]   = v_s1;
	assign dv_rem[0] = num_s1;
	assign dv_qs[0]  = '0;
	assign dv_den[0] = den_s1;
	assign dv_tag[0] = tag_s1;

	for (genvar i = 0; i < DIV_N; i++) begin : g_div
		sbtg_div_cell #(.RW(WW), .QW(XW), .TW(T1W)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_i   (dv_v[i]),
			.rem_i (dv_rem[i]),
			.qs_i  (dv_qs[i]),
			.dv_i  (dv_den[i]),
			.tag_i (dv_tag[i]),
			.v_o   (dv_v[i+1]),
			.rem_o (dv_rem[i+1]),
			.qs_o  (dv_qs[i+1]),
			.dv_o  (dv_den[i+1]),
			.tag_o (dv_tag[i+1])
		);
	end

	// stage 2: u = x^2
	logic [2*XW-1:0] xx_c;
	logic            v_s2;
	logic [XW-1:0]   u_s2;
	logic [THW-1:0]  tag_s2;

	assign xx_c = (2*XW)'(dv_qs[DIV_N]) * (2*XW)'(dv_qs[DIV_N]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= dv_v[DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s2   <= xx_c[2*XW-1:XW];
			tag_s2 <= {dv_qs[DIV_N], dv_tag[DIV_N]};
		end
	end

	// sine polynomial
	logic           hn_v   [HN+1];
	logic [XW-1:0]  hn_u   [HN+1];
	logic [PWS-1:0] hn_p   [HN+1];
	logic [THW-1:0] hn_tag [HN+1];

	assign hn_v[0]   = v_s2;
	assign hn_u[0]   = u_s2;
	assign hn_p[0]   = sbtg_pkg::SIN_C9;
	assign hn_tag[0] = tag_s2;

	for (genvar i = 0; i < HN; i++) begin : g_horner
		sbtg_horner_cell #(.COEF(sbtg_pkg::SIN_HORNER[i]), .TW(THW)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_i   (hn_v[i]),
			.u_i   (hn_u[i]),
			.p_i   (hn_p[i]),
			.tag_i (hn_tag[i]),
			.v_o   (hn_v[i+1]),
			.u_o   (hn_u[i+1]),
			.p_o   (hn_p[i+1]),
			.tag_o (hn_tag[i+1])
		);
	end

	// stage 3: s = x * p
	logic [XW+PWS-1:0] xp_c;
	logic              v_s3;
	logic [PWS-1:0]    s_s3;
	logic [T1W-1:0]    tag_s3;

	assign xp_c = (XW+PWS)'(hn_tag[HN][THW-1:T1W]) * (XW+PWS)'(hn_p[HN]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= hn_v[HN];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s3   <= xp_c[XW+PWS-1:XW];
			tag_s3 <= hn_tag[HN][T1W-1:0];
		end
	end

	// stage 4: s^2
	logic           v_s4;
	logic [61:0]    ss_s4;
	logic [T1W-1:0] tag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s4  <= 62'(s_s3) * 62'(s_s3);
			tag_s4 <= tag_s3;
		end
	end

	// stage 5: rounded gain, limited to one
	logic [62:0]   gsum_c;
	logic [F+2:0]  graw_c;
	logic [GW-1:0] g_c;
	logic          v_s5;
	logic [GW-1:0] g_s5;
	logic [TRW-1:0] tag_s5;

	assign gsum_c = {1'b0, ss_s4} + G_RND;
	assign graw_c = gsum_c[62:60-F];

	always_comb begin
		if (tag_s4[SW+1]) begin
			g_c = '0;
		end else if (tag_s4[SW] || graw_c > (F+3)'(GAIN_ONE)) begin
			g_c = GAIN_ONE;
		end else begin
			g_c = GW'(graw_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	// tag: {enable, kind, neg, mag}
	always_ff @(posedge clk) begin
		if (en) begin
			g_s5   <= g_c;
			tag_s5 <= {tag_s4[SW+3], tag_s4[SW+4], tag_s4[SW+2], tag_s4[SW-1:0]};
		end
	end

	// reciprocal select: pass through, zero stays zero, clip to positive limit
	function automatic logic [GW:0] rcp_pick(input logic on, input logic [GW-1:0] g,
			input logic [DW-1:0] q);
		logic [GW:0] r;
		if (!on) begin
			r = {1'b0, g};
		end else if (g == '0) begin
			r = '0;
		end else if (q > LIM_DW) begin
			r = {1'b1, LIM_GW};
		end else begin
			r = {1'b0, q[GW-1:0]};
		end
		return r;
	endfunction

	// reciprocal A (invert_gain)
	logic           ra_v   [DW+1];
	logic [GW-1:0]  ra_rem [DW+1];
	logic [DW-1:0]  ra_qs  [DW+1];
	logic [GW-1:0]  ra_dv  [DW+1];
	logic [TRW-1:0] ra_tag [DW+1];

	assign ra_v[0]   = v_s5;
	assign ra_rem[0] = '0;
	assign ra_qs[0]  = RCP_ONE + DW'(g_s5[GW-1:1]);
	assign ra_dv[0]  = g_s5;
	assign ra_tag[0] = tag_s5;

	for (genvar i = 0; i < DW; i++) begin : g_rcp_a
		sbtg_div_cell #(.RW(GW), .QW(DW), .TW(TRW)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_i   (ra_v[i]),
			.rem_i (ra_rem[i]),
			.qs_i  (ra_qs[i]),
			.dv_i  (ra_dv[i]),
			.tag_i (ra_tag[i]),
			.v_o   (ra_v[i+1]),
			.rem_o (ra_rem[i+1]),
			.qs_o  (ra_qs[i+1]),
			.dv_o  (ra_dv[i+1]),
			.tag_o (ra_tag[i+1])
		);
	end

	logic [GW:0]    pa_c;
	logic           v_s6;
	logic [GW-1:0]  g_s6;
	logic [TRW-1:0] tag_s6;

	assign pa_c = rcp_pick(ra_tag[DW][SW+2], ra_dv[DW], ra_qs[DW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= ra_v[DW];
		end
	end

	// tag: {enable (kind), sat, neg, mag}
	always_ff @(posedge clk) begin
		if (en) begin
			g_s6   <= pa_c[GW-1:0];
			tag_s6 <= {ra_tag[DW][SW+1], pa_c[GW], ra_tag[DW][SW:0]};
		end
	end

	// reciprocal B (left inverse)
	logic           rb_v   [DW+1];
	logic [GW-1:0]  rb_rem [DW+1];
	logic [DW-1:0]  rb_qs  [DW+1];
	logic [GW-1:0]  rb_dv  [DW+1];
	logic [TRW-1:0] rb_tag [DW+1];

	assign rb_v[0]   = v_s6;
	assign rb_rem[0] = '0;
	assign rb_qs[0]  = RCP_ONE + DW'(g_s6[GW-1:1]);
	assign rb_dv[0]  = g_s6;
	assign rb_tag[0] = tag_s6;

	for (genvar i = 0; i < DW; i++) begin : g_rcp_b
		sbtg_div_cell #(.RW(GW), .QW(DW), .TW(TRW)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_i   (rb_v[i]),
			.rem_i (rb_rem[i]),
			.qs_i  (rb_qs[i]),
			.dv_i  (rb_dv[i]),
			.tag_i (rb_tag[i]),
			.v_o   (rb_v[i+1]),
			.rem_o (rb_rem[i+1]),
			.qs_o  (rb_qs[i+1]),
			.dv_o  (rb_dv[i+1]),
			.tag_o (rb_tag[i+1])
		);
	end

	logic [GW:0]   pb_c;
	logic          v_s7;
	logic [GW-1:0] g_s7;
	logic          sat_s7;
	logic          neg_s7;
	logic [SW-1:0] mag_s7;

	assign pb_c = rcp_pick(rb_tag[DW][SW+2], rb_dv[DW], rb_qs[DW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= rb_v[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s7   <= pb_c[GW-1:0];
			sat_s7 <= pb_c[GW] | rb_tag[DW][SW+1];
			neg_s7 <= rb_tag[DW][SW];
			mag_s7 <= rb_tag[DW][SW-1:0];
		end
	end

	// stage 8: 32x32 partial products of |sample| * gain
	logic [NA*32-1:0] mag_ext;
	logic [NB*32-1:0] g_ext;
	logic             v_s8;
	logic [63:0]      pp_s8 [NA*NB];
	logic             sat_s8;
	logic             neg_s8;

	assign mag_ext = (NA*32)'(mag_s7);
	assign g_ext   = (NB*32)'(g_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s8[i*NB+j] <= 64'(mag_ext[32*i +: 32]) * 64'(g_ext[32*j +: 32]);
				end
			end
			sat_s8 <= sat_s7;
			neg_s8 <= neg_s7;
		end
	end

	// stage 9: sum partial products, round half away from zero
	logic [PW-1:0] acc_c;
	logic [FW-1:0] full_s9;
	logic          sat_s9;
	logic          neg_s9;

	always_comb begin
		acc_c = P_RND;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc_c = acc_c + (PW'(pp_s8[i*NB+j]) << (32 * (i + j)));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			full_s9 <= acc_c[PW-1:F];
			sat_s9  <= sat_s8;
			neg_s9  <= neg_s8;
		end
	end

	// output register: clip, restore sign
	logic [FW-1:0] lim_c;
	logic          over_c;
	logic [SW-1:0] q_c;
	logic [SW-1:0] val_q;
	logic          sat_q;

	assign lim_c  = LIM_FW + FW'(neg_s9);
	assign over_c = full_s9 > lim_c;
	assign q_c    = over_c ? lim_c[SW-1:0] : full_s9[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			val_q <= neg_s9 ? (SW'(0) - q_c) : q_c;
			sat_q <= sat_s9 | over_c;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.filtered_value = val_q;
	assign result.saturated      = sat_q;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> v_s1)
		else $error("accepted transfer did not enter stage 1");

	a_gain_limit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (g_s5 <= GAIN_ONE))
		else $error("taper gain above one");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready && v_s9) |-> !item.ready)
		else $error("pipeline advanced over a waiting result");

endmodule

FILE: dv/tb.sv
// Self-checking bench for spectral_band_taper_gain: directed table, then random stream.
module tb;

	localparam int unsigned GF = 16;
	localparam int unsigned SW = 32;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] GAIN_ONE = 64'd1 << GF;
	localparam logic [63:0] POS_LIMIT = (64'd1 << (SW - 1)) - 1;
	localparam int unsigned DRAIN_CYCLES = 120;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned LONG_HOLD = 400;

	typedef struct {
		logic [SW-1:0] value;
		logic          sat;
	} filtered_t;

	typedef struct {
		logic [1:0]  mode;
		logic [15:0] lo;
		logic [15:0] pk;
		logic [15:0] hi;
		logic        inv;
	} band_cfg_t;

	typedef struct {
		int            cfg;
		logic          kind;
		logic [15:0]   wn;
		logic [SW-1:0] sample;
		bit            typed;
		logic [SW-1:0] want;
		logic          want_sat;
	} vector_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [sbtg_pkg::IDX_W-1:0] wr_index;
	logic [sbtg_pkg::CFG_W-1:0] wr_data;

	sbtg_item_if #(.SAMPLE_WIDTH(SW)) item_ch();
	sbtg_result_if #(.SAMPLE_WIDTH(SW)) result_ch();

	spectral_band_taper_gain #(.GAIN_FRAC_BITS(GF), .SAMPLE_WIDTH(SW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.item(item_ch),
		.result(result_ch)
	);

	band_cfg_t cur_cfg;
	filtered_t pending_results[$];
	filtered_t typed_results[$];
	bit typed_flags[$];
	int mismatches;
	int idle_cycles;
	bit hold_req;
	bit calm;

	band_cfg_t cfg_table[8];
	vector_t directed[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] taper_gain(logic [63:0] num, logic [63:0] den);
		logic [63:0] x, u, p, s, g;
		if (den == 0 || num == 0)
			return 0;
		x = (num << 30) / den;
		if (x >= Q30_ONE)
			return GAIN_ONE;
		u = (x * x) >> 30;
		p = 64'(sbtg_pkg::SIN_C7) - ((u * 64'(sbtg_pkg::SIN_C9)) >> 30);
		p = 64'(sbtg_pkg::SIN_C5) - ((u * p) >> 30);
		p = 64'(sbtg_pkg::SIN_C3) - ((u * p) >> 30);
		p = 64'(sbtg_pkg::SIN_C1) - ((u * p) >> 30);
		s = (x * p) >> 30;
		g = (s * s + (64'd1 << (59 - GF))) >> (60 - GF);
		return g > GAIN_ONE ? GAIN_ONE : g;
	endfunction

	function automatic logic [63:0] gain_for_wavenumber(logic [63:0] k);
		logic [63:0] lo, pk, hi;
		lo = cur_cfg.lo;
		pk = cur_cfg.pk;
		hi = cur_cfg.hi;
		case (cur_cfg.mode)
			sbtg_pkg::MODE_BAND_PASS: begin
				if (k > lo && k <= pk)
					return taper_gain(k - lo, pk - lo);
				if (k > pk && k < hi)
					return taper_gain(hi - k, hi - pk);
				return 0;
			end
			sbtg_pkg::MODE_HIGH_PASS: begin
				if (k > pk)
					return GAIN_ONE;
				if (k > lo)
					return taper_gain(k - lo, pk - lo);
				return 0;
			end
			sbtg_pkg::MODE_LOW_PASS: begin
				if (k < pk)
					return GAIN_ONE;
				if (k <= hi)
					return taper_gain(hi - k, hi - pk);
				return 0;
			end
			default: return 0;
		endcase
	endfunction

	function automatic logic [63:0] reciprocal_gain(logic [63:0] g, inout logic sat);
		logic [63:0] r;
		if (g == 0)
			return 0;
		r = ((64'd1 << (2 * GF)) + g / 2) / g;
		if (r > POS_LIMIT) begin
			r = POS_LIMIT;
			sat = 1'b1;
		end
		return r;
	endfunction

	function automatic filtered_t filter_sample(logic kind, logic [15:0] wn, logic [SW-1:0] raw);
		filtered_t res;
		logic sat, neg;
		logic [SW-1:0] neg_raw;
		logic [63:0] mag, g, lim;
		logic [127:0] prod, q;
		sat = 1'b0;
		neg = raw[SW-1];
		neg_raw = ~raw + 1'b1;
		mag = neg ? 64'(neg_raw) : 64'(raw);
		g = gain_for_wavenumber(64'(wn));
		if (cur_cfg.inv)
			g = reciprocal_gain(g, sat);
		if (kind)
			g = reciprocal_gain(g, sat);
		prod = 128'(mag) * 128'(g) + (128'd1 << (GF - 1));
		q = prod >> GF;
		lim = neg ? POS_LIMIT + 1 : POS_LIMIT;
		if (q > 128'(lim)) begin
			q = 128'(lim);
			sat = 1'b1;
		end
		res.value = neg ? SW'(-q) : SW'(q);
		res.sat = sat;
		return res;
	endfunction

	always @(posedge clk) begin
		filtered_t exp_r, typ;
		bit typed;
		if (arst_n && item_ch.valid && item_ch.ready)
			pending_results.push_back(filter_sample(item_ch.kind, item_ch.wavenumber,
				item_ch.sample_value));
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h sat %b", result_ch.filtered_value,
						result_ch.saturated);
			end else begin
				exp_r = pending_results.pop_front();
				typ = typed_results.pop_front();
				typed = typed_flags.pop_front();
				if (typed && (typ.value !== exp_r.value || typ.sat !== exp_r.sat)) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table entry %h/%b disagrees with predictor %h/%b",
							typ.value, typ.sat, exp_r.value, exp_r.sat);
				end
				if (result_ch.filtered_value !== exp_r.value
						|| result_ch.saturated !== exp_r.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h sat %b, got %h sat %b", exp_r.value,
							exp_r.sat, result_ch.filtered_value, result_ch.saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("spectral_band_taper_gain verification failed");
				$finish;
			end
		end
	end

	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (calm || $urandom_range(0, 3) != 0)
				result_ch.ready <= 1'b1;
			else begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	task automatic write_reg(sbtg_pkg::reg_index_t idx, logic [sbtg_pkg::CFG_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_band(band_cfg_t c);
		drain();
		write_reg(sbtg_pkg::REG_BAND_MODE, sbtg_pkg::CFG_W'(c.mode));
		write_reg(sbtg_pkg::REG_BAND_MIN, c.lo);
		write_reg(sbtg_pkg::REG_BAND_PEAK, c.pk);
		write_reg(sbtg_pkg::REG_BAND_MAX, c.hi);
		write_reg(sbtg_pkg::REG_INVERT_GAIN, sbtg_pkg::CFG_W'(c.inv));
		cur_cfg = c;
	endtask

	task automatic send_item(logic kind, logic [15:0] wn, logic [SW-1:0] sample);
		if (!calm && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= kind;
		item_ch.wavenumber <= wn;
		item_ch.sample_value <= sample;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	function automatic vector_t row(int c, logic kind, logic [15:0] wn, logic [SW-1:0] s,
			bit typed = 1'b0, logic [SW-1:0] want = '0, logic want_sat = 1'b0);
		vector_t v;
		v.cfg = c;
		v.kind = kind;
		v.wn = wn;
		v.sample = s;
		v.typed = typed;
		v.want = want;
		v.want_sat = want_sat;
		return v;
	endfunction

	initial begin
		band_cfg_t rc;
		int prev_cfg;
		int n;
		filtered_t typ;
		logic [15:0] wn;
		logic [15:0] a, b, c;
		mismatches = 0;
		idle_cycles = 0;
		hold_req = 1'b0;
		calm = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		item_ch.valid = 1'b0;
		item_ch.kind = 1'b0;
		item_ch.wavenumber = '0;
		item_ch.sample_value = '0;
		cur_cfg = '{sbtg_pkg::MODE_BAND_PASS, 16'd0, 16'd0, 16'd0, 1'b0};

		cfg_table[0] = cur_cfg;
		cfg_table[1] = '{sbtg_pkg::MODE_HIGH_PASS, 16'd0, 16'd16, 16'd0, 1'b0};
		cfg_table[2] = '{sbtg_pkg::MODE_BAND_PASS, 16'd100, 16'd500, 16'd900, 1'b0};
		cfg_table[3] = '{sbtg_pkg::MODE_LOW_PASS, 16'd0, 16'd1000, 16'd2000, 1'b1};
		cfg_table[4] = '{2'd3, 16'd0, 16'd100, 16'd200, 1'b0};
		cfg_table[5] = '{sbtg_pkg::MODE_LOW_PASS, 16'd0, 16'd800, 16'd800, 1'b0};
		cfg_table[6] = '{sbtg_pkg::MODE_BAND_PASS, 16'd900, 16'd500, 16'd100, 1'b0};
		cfg_table[7] = '{sbtg_pkg::MODE_BAND_PASS, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1};

		// after reset every gain is zero
		directed.push_back(row(0, 1'b0, 16'hFFFF, 32'h7FFFFFFF, 1'b1, 32'd0, 1'b0));
		directed.push_back(row(0, 1'b1, 16'd0, 32'h80000000, 1'b1, 32'd0, 1'b0));
		// unity gain passes the sample through
		directed.push_back(row(1, 1'b0, 16'hFFFF, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 1'b0));
		directed.push_back(row(1, 1'b1, 16'd17, 32'h80000000, 1'b1, 32'h80000000, 1'b0));
		directed.push_back(row(1, 1'b0, 16'd8, 32'h00012345));
		directed.push_back(row(2, 1'b0, 16'd100, 32'h00010000));
		directed.push_back(row(2, 1'b0, 16'd101, 32'hFFFF0000));
		directed.push_back(row(2, 1'b0, 16'd300, 32'h7FFFFFFF));
		directed.push_back(row(2, 1'b0, 16'd500, 32'h80000000));
		directed.push_back(row(2, 1'b1, 16'd501, 32'h00010000));
		directed.push_back(row(2, 1'b1, 16'd899, 32'h00010000));
		directed.push_back(row(2, 1'b0, 16'd900, 32'h00010000));
		directed.push_back(row(3, 1'b0, 16'd1999, 32'h00010000));
		directed.push_back(row(3, 1'b1, 16'd1999, 32'h00010000));
		directed.push_back(row(3, 1'b0, 16'd2000, 32'h00010000, 1'b1, 32'd0, 1'b0));
		directed.push_back(row(3, 1'b1, 16'd10, 32'h80000000));
		directed.push_back(row(4, 1'b0, 16'd50, 32'h7FFFFFFF, 1'b1, 32'd0, 1'b0));
		directed.push_back(row(4, 1'b1, 16'd150, 32'h12345678, 1'b1, 32'd0, 1'b0));
		directed.push_back(row(5, 1'b0, 16'd800, 32'h00010000, 1'b1, 32'd0, 1'b0));
		directed.push_back(row(5, 1'b0, 16'd799, 32'h00010000, 1'b1, 32'h00010000, 1'b0));
		directed.push_back(row(6, 1'b0, 16'd700, 32'h00010000, 1'b1, 32'd0, 1'b0));
		directed.push_back(row(6, 1'b0, 16'd300, 32'h00010000, 1'b1, 32'd0, 1'b0));
		directed.push_back(row(7, 1'b0, 16'd1, 32'h7FFFFFFF));
		directed.push_back(row(7, 1'b1, 16'hFFFE, 32'h80000001));
		directed.push_back(row(7, 1'b0, 16'hFFFF, 32'h00010000));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_cfg = 0;
		foreach (directed[i]) begin
			if (directed[i].cfg != prev_cfg) begin
				load_band(cfg_table[directed[i].cfg]);
				prev_cfg = directed[i].cfg;
			end
			typ.value = directed[i].want;
			typ.sat = directed[i].want_sat;
			typed_results.push_back(typ);
			typed_flags.push_back(directed[i].typed);
			send_item(directed[i].kind, directed[i].wn, directed[i].sample);
		end

		for (int ph = 0; ph < 7; ph++) begin
			a = 16'($urandom_range(0, 65535));
			b = 16'($urandom_range(0, 65535));
			c = 16'($urandom_range(0, 65535));
			if ($urandom_range(0, 4) != 0) begin
				// mostly well-ordered bounds
				if (a > b) {a, b} = {b, a};
				if (b > c) {b, c} = {c, b};
				if (a > b) {a, b} = {b, a};
			end
			rc = '{2'($urandom_range(0, 3)), a, b, c, 1'($urandom_range(0, 1))};
			if (ph == 6)
				rc = '{sbtg_pkg::MODE_HIGH_PASS, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0};
			load_band(rc);
			calm = (ph == 6);
			if (ph == 1)
				hold_req = 1'b1;
			n = 95;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 3) == 0)
					wn = 16'($urandom_range(0, 65535));
				else
					wn = 16'($urandom_range(rc.lo < rc.hi ? rc.lo : rc.hi,
						rc.lo < rc.hi ? rc.hi : rc.lo));
				typed_results.push_back(typ);
				typed_flags.push_back(1'b0);
				send_item(1'($urandom_range(0, 1)), wn, SW'($urandom));
				if (ph == 3 && i == 40) begin
					item_ch.valid <= 1'b0;
					while (pending_results.size() != 0)
						@(posedge clk);
				end
			end
		end

		item_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("spectral_band_taper_gain verification clean");
		else
			$display("spectral_band_taper_gain verification failed");
		$finish;
	end
endmodule
